// ===== rtl/rqq_pkg.sv =====
// Shared types and constants for the request queue with FIFO and smallest-key modes.
package rqq_pkg;

	// Default number of queue cells
	localparam int unsigned DEPTH_DEF = 16;

	// Fixed field widths
	localparam int CONN_W   = 16;
	localparam int KEY_W    = 32;
	localparam int FILL_W   = 5;
	localparam int CAP_W    = 5;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 5;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd1;

	// Reset values of the registers
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

	// Operation codes of an input item
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Order modes
	localparam logic MODE_FIFO = 1'b0;
	localparam logic MODE_KEY  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// What a cell loads in a cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_NEXT,
		CELL_HEAD
	} cell_cmd_t;

	// Controller states
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} rqq_state_t;

	// One result item
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CONN_W-1:0]   conn;
		logic [KEY_W-1:0]    key;
		logic [FILL_W-1:0]   fill;
	} res_t;

endpackage

// ===== rtl/rqq_cell.sv =====
// One storage cell of the queue row: holds one entry and loads a new item, its neighbour or the head.
module rqq_cell (
	input  logic                     clk,
	input  rqq_pkg::cell_cmd_t       cmd,
	input  logic [rqq_pkg::CONN_W-1:0] in_conn,
	input  logic [rqq_pkg::KEY_W-1:0]  in_key,
	input  logic [rqq_pkg::CONN_W-1:0] nxt_conn,
	input  logic [rqq_pkg::KEY_W-1:0]  nxt_key,
	input  logic [rqq_pkg::CONN_W-1:0] head_conn,
	input  logic [rqq_pkg::KEY_W-1:0]  head_key,
	output logic [rqq_pkg::CONN_W-1:0] conn,
	output logic [rqq_pkg::KEY_W-1:0]  key
);
	import rqq_pkg::*;

	logic [CONN_W-1:0] conn_q;
	logic [KEY_W-1:0]  key_q;

	// Load a new item, take the younger neighbour, or wrap the head round
	always_ff @(posedge clk) begin
		case (cmd)
			CELL_LOAD: begin
				conn_q <= in_conn;
				key_q  <= in_key;
			end
			CELL_NEXT: begin
				conn_q <= nxt_conn;
				key_q  <= nxt_key;
			end
			CELL_HEAD: begin
				conn_q <= head_conn;
				key_q  <= head_key;
			end
			default: begin
				conn_q <= conn_q;
				key_q  <= key_q;
			end
		endcase
	end

	assign conn = conn_q;
	assign key  = key_q;

endmodule

// ===== rtl/rqq_outq.sv =====
// Two-slot result queue that parts the output handshake from the cell row.
module rqq_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  rqq_pkg::res_t wdata,
	output logic          full,
	output logic          out_valid,
	input  logic          out_stall,
	output rqq_pkg::res_t out_res
);
	import rqq_pkg::*;

	logic v0_q, v1_q;
	logic v0_d, v1_d;
	res_t s0_q, s1_q;
	logic pop;
	logic ld0, ld0_from1, ld1;

	assign pop = v0_q && !out_stall;

	// Work out slot moves for this cycle
	always_comb begin
		v0_d      = v0_q;
		v1_d      = v1_q;
		ld0       = 1'b0;
		ld0_from1 = 1'b0;
		ld1       = 1'b0;
		if (pop) begin
			if (v1_q) begin
				ld0_from1 = 1'b1;
				ld1       = we;
				v1_d      = we;
				v0_d      = 1'b1;
			end else begin
				ld0  = we;
				v0_d = we;
			end
		end else if (we) begin
			if (!v0_q) begin
				ld0  = 1'b1;
				v0_d = 1'b1;
			end else begin
				ld1  = 1'b1;
				v1_d = 1'b1;
			end
		end
	end

	// Hold slot valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			v0_q <= v0_d;
			v1_q <= v1_d;
		end
	end

	// Move result payloads
	always_ff @(posedge clk) begin
		if (ld0_from1) begin
			s0_q <= s1_q;
		end else if (ld0) begin
			s0_q <= wdata;
		end
		if (ld1) begin
			s1_q <= wdata;
		end
	end

	assign full      = v1_q;
	assign out_valid = v0_q;
	assign out_res   = s0_q;

`ifndef ASSERT_OFF
	// A result never arrives while both slots are held and none leaves
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && v1_q && !pop))
		else $error("result queue overflow");

	// The skid slot is only ever used behind the output slot
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q)
		else $error("skid slot held with output slot empty");

	// A taken item with a queued one behind it keeps the output valid
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && v1_q) |=> out_valid)
		else $error("queued result lost after output taken");
`endif

endmodule

// ===== rtl/fifo_or_min_key_request_queue.sv =====
// Top level of the request queue: controller, cell row and result queue.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | into      | in_valid / in_stall | op, conn_id, prio_key
//  out     | out of    | out_valid/out_stall | status, out_conn_id, out_key, fill_level
//  cfg     | into      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Push, FIFO pop and refused items are handled in the idle state; a smallest-key pop scans
// with the single key comparator at cell 0 while the row rotates past it once.
// Reset clears the fill, mode (FIFO), capacity (16) and the result queue; cells hold
// no reset value and need no clearing pass.
// The input stalls during a key scan, and when both result slots are held.
module fifo_or_min_key_request_queue #(
	parameter int unsigned DEPTH = rqq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input items
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [rqq_pkg::CONN_W-1:0]    conn_id,
	input  logic [rqq_pkg::KEY_W-1:0]     prio_key,
	// Result items
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rqq_pkg::STATUS_W-1:0]  status,
	output logic [rqq_pkg::CONN_W-1:0]    out_conn_id,
	output logic [rqq_pkg::KEY_W-1:0]     out_key,
	output logic [rqq_pkg::FILL_W-1:0]    fill_level,
	// Register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rqq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rqq_pkg::CFG_DAT_W-1:0] cfg_data
);
	import rqq_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Registers and control
	logic              mode_q;
	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  k_q;
	logic [IDX_W-1:0]  pos_q;
	logic [CONN_W-1:0] best_conn_q;
	logic [KEY_W-1:0]  best_key_q;
	rqq_state_t        state_q, state_d;

	logic              accept;
	logic              outq_full;
	logic              queue_full;
	logic              load_en, rot_en, compact_en;
	logic [IDX_W-1:0]  cpos;
	logic              scan_start, scan_step;
	logic              cnt_inc, cnt_dec;
	logic              res_we;
	res_t              res_d;
	res_t              out_res;

	logic [CONN_W-1:0] cell_conn [DEPTH];
	logic [KEY_W-1:0]  cell_key  [DEPTH];
	cell_cmd_t         cell_cmd  [DEPTH];

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE) || outq_full;

	// Push refused once fill reaches the usable capacity (zero counts as one)
	assign queue_full = (count_q == CNT_W'(DEPTH))
		|| ((cap_q != '0) && (CMP_W'(count_q) >= CMP_W'(cap_q)))
		|| ((cap_q == '0) && (count_q != '0));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (op == OP_POP) && (count_q != '0) && (mode_q == MODE_KEY)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (k_q == count_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		load_en    = 1'b0;
		rot_en     = 1'b0;
		compact_en = 1'b0;
		cpos       = '0;
		scan_start = 1'b0;
		scan_step  = 1'b0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		res_we     = 1'b0;
		res_d      = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_PUSH) begin
						res_we = 1'b1;
						if (queue_full) begin
							res_d.status = STATUS_FULL;
							res_d.fill   = FILL_W'(count_q);
						end else begin
							load_en      = 1'b1;
							cnt_inc      = 1'b1;
							res_d.status = STATUS_DONE;
							res_d.fill   = FILL_W'(count_q + CNT_W'(1));
						end
					end else if (count_q == '0) begin
						res_we       = 1'b1;
						res_d.status = STATUS_EMPTY;
					end else if (mode_q == MODE_FIFO) begin
						res_we       = 1'b1;
						compact_en   = 1'b1;
						cnt_dec      = 1'b1;
						res_d.status = STATUS_DONE;
						res_d.conn   = cell_conn[0];
						res_d.key    = cell_key[0];
						res_d.fill   = FILL_W'(count_q - CNT_W'(1));
					end else begin
						rot_en     = 1'b1;
						scan_start = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (k_q == count_q) begin
					res_we       = 1'b1;
					compact_en   = 1'b1;
					cpos         = pos_q;
					cnt_dec      = 1'b1;
					res_d.status = STATUS_DONE;
					res_d.conn   = best_conn_q;
					res_d.key    = best_key_q;
					res_d.fill   = FILL_W'(count_q - CNT_W'(1));
				end else begin
					rot_en    = 1'b1;
					scan_step = 1'b1;
				end
			end
			default: begin
				res_we = 1'b0;
			end
		endcase
	end

	// Hold state, fill, scan position and the mode and capacity registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			k_q     <= '0;
			mode_q  <= MODE_FIFO;
			cap_q   <= CAPACITY_RESET;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (scan_start) begin
				k_q <= CNT_W'(1);
			end else if (scan_step) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ORDER_MODE) begin
					mode_q <= cfg_data[0];
				end else if (cfg_index == REG_CAPACITY) begin
					cap_q <= cfg_data;
				end
			end
		end
	end

	// Track the oldest least key as the row rotates past cell 0
	always_ff @(posedge clk) begin
		if (scan_start) begin
			best_conn_q <= cell_conn[0];
			best_key_q  <= cell_key[0];
			pos_q       <= '0;
		end else if (scan_step && (cell_key[0] < best_key_q)) begin
			best_conn_q <= cell_conn[0];
			best_key_q  <= cell_key[0];
			pos_q       <= k_q[IDX_W-1:0];
		end
	end

	// Row of cells, oldest entry in cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] CI = CNT_W'(i);
		localparam logic [IDX_W-1:0] PI = IDX_W'(i);
		logic [CONN_W-1:0] nxt_conn;
		logic [KEY_W-1:0]  nxt_key;

		if (i == DEPTH - 1) begin : g_last
			assign nxt_conn = cell_conn[i];
			assign nxt_key  = cell_key[i];
		end else begin : g_mid
			assign nxt_conn = cell_conn[i+1];
			assign nxt_key  = cell_key[i+1];
		end

		// Choose what this cell takes
		always_comb begin
			cell_cmd[i] = CELL_HOLD;
			if (load_en && (CI == count_q)) begin
				cell_cmd[i] = CELL_LOAD;
			end else if (compact_en && (PI >= cpos)) begin
				cell_cmd[i] = CELL_NEXT;
			end else if (rot_en && (CI < count_q)) begin
				if (CI == count_q - CNT_W'(1)) begin
					cell_cmd[i] = CELL_HEAD;
				end else begin
					cell_cmd[i] = CELL_NEXT;
				end
			end
		end

		rqq_cell u_cell (
			.clk       (clk),
			.cmd       (cell_cmd[i]),
			.in_conn   (conn_id),
			.in_key    (prio_key),
			.nxt_conn  (nxt_conn),
			.nxt_key   (nxt_key),
			.head_conn (cell_conn[0]),
			.head_key  (cell_key[0]),
			.conn      (cell_conn[i]),
			.key       (cell_key[i])
		);
	end

	// Result queue
	rqq_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (res_we),
		.wdata     (res_d),
		.full      (outq_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign status      = out_res.status;
	assign out_conn_id = out_res.conn;
	assign out_key     = out_res.key;
	assign fill_level  = out_res.fill;

`ifndef ASSERT_OFF
	// Fill never exceeds the cell row
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill above depth");

	// A scan stays within the held entries
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((k_q != '0) && (k_q <= count_q)))
		else $error("scan position out of range");

	// Fill only changes when a result is produced
	a_count_result: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(res_we))
		else $error("fill changed without a result");

	// No item is taken while a key scan runs
	a_scan_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !accept)
		else $error("item accepted during scan");
`endif

endmodule

// ===== dv/rqq_checker.sv =====
// Checker for the request queue: watches all three channels, predicts each result and compares.
`timescale 1ns / 100ps

module rqq_checker #(
	parameter int unsigned DEPTH = rqq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          op,
	input  logic [rqq_pkg::CONN_W-1:0]    conn_id,
	input  logic [rqq_pkg::KEY_W-1:0]     prio_key,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [rqq_pkg::STATUS_W-1:0]  status,
	input  logic [rqq_pkg::CONN_W-1:0]    out_conn_id,
	input  logic [rqq_pkg::KEY_W-1:0]     out_key,
	input  logic [rqq_pkg::FILL_W-1:0]    fill_level,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [rqq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rqq_pkg::CFG_DAT_W-1:0] cfg_data,
	output int                            errors,
	output int                            pending
);
	import rqq_pkg::*;

	typedef struct packed {
		logic [CONN_W-1:0] conn;
		logic [KEY_W-1:0]  key;
	} held_entry_t;

	// Held requests, always kept oldest first
	held_entry_t held_q[$];
	// Results still to come out of the block
	res_t        due_q[$];
	logic        order_mode;
	logic [CAP_W-1:0] cap_reg;

	// Apply one item to the shadow queue and return the result it gives
	function automatic res_t serve_item(input logic item_op, input logic [CONN_W-1:0] item_conn,
			input logic [KEY_W-1:0] item_key);
		res_t        r;
		held_entry_t e;
		int unsigned limit;
		int          best;
		r = '0;
		r.status = STATUS_DONE;
		// zero capacity acts as one, anything above the depth saturates
		limit = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
		if (item_op == OP_PUSH) begin
			if (held_q.size() >= limit) begin
				r.status = STATUS_FULL;
			end else begin
				e.conn = item_conn;
				e.key = item_key;
				held_q.push_back(e);
			end
			r.fill = FILL_W'(held_q.size());
		end else if (held_q.size() == 0) begin
			r.status = STATUS_EMPTY;
		end else begin
			best = 0;
			// strict less keeps the oldest among equal keys
			if (order_mode == MODE_KEY) begin
				for (int i = 1; i < held_q.size(); i++)
					if (held_q[i].key < held_q[best].key)
						best = i;
			end
			r.conn = held_q[best].conn;
			r.key = held_q[best].key;
			held_q.delete(best);
			r.fill = FILL_W'(held_q.size());
		end
		return r;
	endfunction

	// Track register writes, predict on input, compare on output
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			held_q.delete();
			due_q.delete();
			order_mode = MODE_FIFO;
			cap_reg = CAPACITY_RESET;
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ORDER_MODE)
					order_mode = cfg_data[0];
				else if (cfg_index == REG_CAPACITY)
					cap_reg = cfg_data;
			end
			if (in_valid && !in_stall)
				due_q.push_back(serve_item(op, conn_id, prio_key));
			if (out_valid && !out_stall) begin
				if (due_q.size() == 0) begin
					$error("unexpected result: status %0d conn %h key %h fill %0d",
						status, out_conn_id, out_key, fill_level);
					errors++;
				end else begin
					want = due_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (out_conn_id !== want.conn) begin
						$error("out_conn_id: expected %h, got %h", want.conn, out_conn_id);
						errors++;
					end
					if (out_key !== want.key) begin
						$error("out_key: expected %h, got %h", want.key, out_key);
						errors++;
					end
					if (fill_level !== want.fill) begin
						$error("fill_level: expected %0d, got %0d", want.fill, fill_level);
						errors++;
					end
				end
			end
			pending = due_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// Top of the request queue testbench: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 100ps

module tb;
	import rqq_pkg::*;

	localparam int unsigned DEPTH = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	// Indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 op;
	logic [CONN_W-1:0]    conn_id;
	logic [KEY_W-1:0]     prio_key;
	logic                 out_valid;
	logic                 out_stall;
	logic [STATUS_W-1:0]  status;
	logic [CONN_W-1:0]    out_conn_id;
	logic [KEY_W-1:0]     out_key;
	logic [FILL_W-1:0]    fill_level;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	int                   errors;
	int                   pending;
	int                   cycles = 0;
	int                   items_sent = 0;
	int                   reg_writes = 0;
	int                   in_run = 0;
	int                   out_run = 0;

	always #5 clk = ~clk;

	fifo_or_min_key_request_queue #(.DEPTH(DEPTH)) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.conn_id     (conn_id),
		.prio_key    (prio_key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_conn_id (out_conn_id),
		.out_key     (out_key),
		.fill_level  (fill_level),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	rqq_checker #(.DEPTH(DEPTH)) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.conn_id     (conn_id),
		.prio_key    (prio_key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_conn_id (out_conn_id),
		.out_key     (out_key),
		.fill_level  (fill_level),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.pending     (pending)
	);

	// Idle gap before the next item: mostly drawn at random, now and then a run of items with none
	function automatic int draw_gap(inout int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			run_left = $urandom_range(8, 40);
		return $urandom_range(0, 11);
	endfunction

	// Offer one item and hold it until the block takes it
	task automatic send_item(input logic item_op, input logic [CONN_W-1:0] item_conn,
			input logic [KEY_W-1:0] item_key);
		int gap;
		gap = draw_gap(in_run);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= item_op;
		conn_id <= item_conn;
		prio_key <= item_key;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// Drop valid and wait until every result is out
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Write one register while the queue is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	// Receiver side: stall a random while before each result
	initial begin
		int gap;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(out_run);
			repeat (gap) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		int               ph;
		int               push_pct;
		logic [CAP_W-1:0] cap_val;
		logic [KEY_W-1:0] key_val;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_PUSH;
		conn_id = '0;
		prio_key = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ORDER_MODE;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: FIFO order, full capacity; empty pop and field extremes
		send_item(OP_POP, 16'h0000, 32'h0000_0000);
		send_item(OP_PUSH, 16'h0000, 32'h0000_0000);
		send_item(OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(OP_PUSH, 16'h1234, 32'h0000_0007);
		send_item(OP_POP, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(OP_POP, 16'h0000, 32'h0000_0000);
		send_item(OP_POP, 16'h0000, 32'h0000_0000);
		send_item(OP_POP, 16'h0000, 32'h0000_0000);

		// Zero capacity behaves as one slot
		drain();
		write_reg(REG_CAPACITY, 5'd0);
		send_item(OP_PUSH, 16'hAAAA, 32'h0000_0003);
		send_item(OP_PUSH, 16'h5555, 32'h0000_0001);
		send_item(OP_POP, 16'h0000, 32'h0000_0000);

		// Key order, capacity saturating above the depth, equal keys
		drain();
		write_reg(REG_ORDER_MODE, {4'b0000, MODE_KEY});
		write_reg(REG_CAPACITY, 5'd31);
		send_item(OP_PUSH, 16'h0101, 32'h0000_0009);
		send_item(OP_PUSH, 16'h0202, 32'h0000_0004);
		send_item(OP_PUSH, 16'h0303, 32'h0000_0004);
		send_item(OP_PUSH, 16'h0404, 32'hFFFF_FFFF);

		// Capacity lowered below the fill: the first push refused, pops still served
		drain();
		write_reg(REG_CAPACITY, 5'd2);
		send_item(OP_PUSH, 16'h0505, 32'h0000_0000);
		send_item(OP_POP, 16'h0000, 32'h0000_0000);
		send_item(OP_POP, 16'h0000, 32'h0000_0000);
		send_item(OP_POP, 16'h0000, 32'h0000_0000);
		send_item(OP_PUSH, 16'h0606, 32'h0000_0001);

		// Back to FIFO with entries held
		drain();
		write_reg(REG_ORDER_MODE, {4'b0000, MODE_FIFO});
		send_item(OP_POP, 16'h0000, 32'h0000_0000);
		send_item(OP_POP, 16'h0000, 32'h0000_0000);
		send_item(OP_POP, 16'h0000, 32'h0000_0000);

		// Writes to indexes with no register must change nothing
		drain();
		write_reg(REG_SPARE_A, 5'd31);
		write_reg(REG_SPARE_B, 5'd0);

		// Random phases, each with its own mode, capacity and push share
		for (ph = 0; ph < 8; ph++) begin
			drain();
			write_reg(REG_ORDER_MODE, CFG_DAT_W'($urandom_range(0, 31)));
			case ($urandom_range(0, 5))
				0: cap_val = 5'd0;
				1: cap_val = 5'd1;
				2: cap_val = 5'd16;
				3: cap_val = 5'd31;
				default: cap_val = CAP_W'($urandom_range(0, 31));
			endcase
			write_reg(REG_CAPACITY, cap_val);
			push_pct = 30 + 20 * $urandom_range(0, 3);
			repeat (50) begin
				if ($urandom_range(1, 100) <= push_pct) begin
					// few distinct small keys give plenty of ties
					case ($urandom_range(0, 5))
						0: key_val = 32'h0000_0000;
						1: key_val = 32'hFFFF_FFFF;
						2, 3: key_val = $urandom_range(0, 3);
						default: key_val = $urandom;
					endcase
					send_item(OP_PUSH, CONN_W'($urandom_range(0, 65535)), key_val);
				end else begin
					send_item(OP_POP, CONN_W'($urandom_range(0, 65535)), $urandom);
				end
			end
		end

		drain();
		repeat (2 * DEPTH + 4) @(negedge clk);
		$display("tb: %0d items and %0d register writes, FIFO and key order,", items_sent,
			reg_writes);
		$display("tb: capacities 0 to 31, full and empty refusals, ties and mode changes");
		if (errors == 0 && pending == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
